// File: rtl/clcd_pkg.sv
// ============================================================================
// clcd_pkg
// Shared types, constants and address helpers for the character LCD core.
// ============================================================================
package clcd_pkg;

    // Display and glyph geometry
    localparam int ROWS        = 4;
    localparam int COLS        = 20;
    localparam int GLYPHS      = 8;
    localparam int GLYPH_LINES = 8;
    localparam int CELLS       = ROWS * COLS;
    localparam int GLYPH_CELLS = GLYPHS * GLYPH_LINES;

    localparam int CELL_AW  = 7;   // display store index / address counter
    localparam int GLYPH_AW = 6;   // glyph store index / address counter
    localparam int GLYPH_DW = 5;   // glyph row width

    // Reset values
    localparam logic [7:0] BLANK_CODE  = 8'h20;
    localparam logic [2:0] ENTRY_RESET = 3'b110;

    // Bus access codes
    localparam logic [1:0] CMD_WRITE      = 2'd0;
    localparam logic [1:0] CMD_READ_CELL  = 2'd1;
    localparam logic [1:0] CMD_READ_GLYPH = 2'd2;

    // Data byte codes
    localparam logic [7:0] CODE_FULL_BLOCK = 8'hFF;
    localparam logic [7:0] CODE_SOLID      = 8'h1F;

    // Instruction codes and decode masks
    localparam logic [7:0] INS_NOP         = 8'h00;
    localparam logic [7:0] INS_CLEAR       = 8'h01;
    localparam logic [7:0] INS_HOME        = 8'h02;
    localparam logic [7:0] MASK_ENTRY      = 8'hFC;
    localparam logic [7:0] INS_ENTRY       = 8'h04;
    localparam logic [7:0] MASK_DISPLAY    = 8'hF8;
    localparam logic [7:0] INS_DISPLAY     = 8'h08;
    localparam logic [7:0] MASK_SHIFT      = 8'hF0;
    localparam logic [7:0] INS_SHIFT       = 8'h10;
    localparam logic [7:0] MASK_FUNCTION   = 8'hE0;
    localparam logic [7:0] INS_FUNCTION    = 8'h20;
    localparam logic [7:0] MASK_SET_CGRAM  = 8'hC0;
    localparam logic [7:0] INS_SET_CGRAM   = 8'h40;

    // Display line start addresses
    localparam logic [CELL_AW-1:0] LINE1_BASE = 7'h40;
    localparam logic [CELL_AW-1:0] LINE2_BASE = 7'h14;
    localparam logic [CELL_AW-1:0] LINE3_BASE = 7'h54;

    // Source of read data for a request in flight
    typedef enum logic [1:0] {
        RD_ZERO,
        RD_CELL,
        RD_GLYPH
    } t_rd_src;

    typedef struct packed {
        logic [1:0] command;
        logic       rs;
        logic [7:0] data_byte;
        logic [1:0] read_row;
        logic [4:0] read_col;
        logic [2:0] glyph_index;
        logic [2:0] glyph_line;
    } t_req;

    typedef struct packed {
        logic [7:0]          read_data;
        logic [CELL_AW-1:0]  ddram_address;
        logic [GLYPH_AW-1:0] cgram_address;
        logic                cgram_selected;
        logic [2:0]          entry_bits;
        logic                display_enabled;
        logic                cursor_enabled;
        logic                blink_enabled;
        logic                seen_activity;
    } t_rsp;

    // Display address counter to store index. The four visible line windows
    // map directly; any other address aliases by column = a mod COLS and
    // row = (a / COLS) mod ROWS.
    function automatic logic [CELL_AW-1:0] cell_index_of(input logic [CELL_AW-1:0] a);
        logic [2:0]         q;
        logic [CELL_AW-1:0] col;
        logic [CELL_AW-1:0] idx;
        if (a < 7'(COLS)) begin
            idx = a;
        end else if (a >= LINE1_BASE && a < LINE1_BASE + 7'(COLS)) begin
            idx = a - LINE1_BASE + 7'(COLS);
        end else if (a >= LINE2_BASE && a < LINE2_BASE + 7'(COLS)) begin
            idx = a - LINE2_BASE + 7'(2 * COLS);
        end else if (a >= LINE3_BASE && a < LINE3_BASE + 7'(COLS)) begin
            idx = a - LINE3_BASE + 7'(3 * COLS);
        end else begin
            // quotient by COLS through a compare chain
            if (a >= 7'(6 * COLS))      q = 3'd6;
            else if (a >= 7'(5 * COLS)) q = 3'd5;
            else if (a >= 7'(4 * COLS)) q = 3'd4;
            else if (a >= 7'(3 * COLS)) q = 3'd3;
            else if (a >= 7'(2 * COLS)) q = 3'd2;
            else                        q = 3'd1;
            col = a - 7'(q) * 7'(COLS);
            idx = 7'(q[1:0]) * 7'(COLS) + col;
        end
        return idx;
    endfunction

endpackage

// File: rtl/clcd_if.sv
// ============================================================================
// clcd request / response channels
// Valid/ready channels carrying one bus access and its result.
// ============================================================================
interface clcd_req_if;
    logic              valid;
    logic              ready;
    clcd_pkg::t_req    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface clcd_rsp_if;
    logic              valid;
    logic              ready;
    clcd_pkg::t_rsp    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/clcd_ram.sv
// ============================================================================
// clcd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module clcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/char_lcd_controller_core.sv
// ============================================================================
// char_lcd_controller_core
// Character LCD controller: 4x20 display store, 8x8 custom glyph store,
// address counters, entry mode and display flags, one result per access.
// ============================================================================
//
//  Channel   Dir  Payload           Meaning
//  i_req     in   clcd_pkg::t_req   bus access: write byte / read cell / glyph
//  o_rsp     out  clcd_pkg::t_rsp   read data plus controller state after it
//
//  One request is taken per cycle while the output is not stalled; its result
//  passes through the registered read of the store RAMs, then the output register.
//  Clear drops the per-cell valid bits; an invalid cell reads as blank, an
//  invalid glyph row as zero.
//  Reset is synchronous, active low, and needs no clearing pass; the input is
//  held not ready while reset is asserted.
//  A stalled output holds its result; the input keeps taking requests until
//  both the read stage and the output register are full.
//
module char_lcd_controller_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    clcd_req_if.sink            i_req,
    clcd_rsp_if.source          o_rsp
);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic                              w_accept;
    logic                              w_p_advance;
    logic                              w_is_write;
    logic [7:0]                        w_byte;

    logic [clcd_pkg::CELL_AW-1:0]      r_caddr,  n_caddr;
    logic [clcd_pkg::GLYPH_AW-1:0]     r_gaddr,  n_gaddr;
    logic                              r_gmode,  n_gmode;
    logic [2:0]                        r_entry,  n_entry;
    logic [2:0]                        r_dflags, n_dflags;
    logic                              r_act,    n_act;
    logic [clcd_pkg::CELLS-1:0]        r_cell_vld, n_cell_vld;
    logic [clcd_pkg::GLYPH_CELLS-1:0]  r_glyph_vld, n_glyph_vld;

    logic                              w_cell_we;
    logic [clcd_pkg::CELL_AW-1:0]      w_cell_waddr;
    logic [7:0]                        w_cell_wdata;
    logic                              w_glyph_we;
    logic [clcd_pkg::GLYPH_DW-1:0]     w_glyph_wdata;

    logic [clcd_pkg::CELL_AW-1:0]      w_cell_raddr;
    logic [clcd_pkg::GLYPH_AW-1:0]     w_glyph_raddr;
    logic [7:0]                        w_cell_rdata;
    logic [clcd_pkg::GLYPH_DW-1:0]     w_glyph_rdata;

    clcd_pkg::t_rd_src                 w_src;
    logic                              w_src_vld;

    logic                              r_p_valid;
    clcd_pkg::t_rd_src                 r_p_src;
    logic                              r_p_vld;
    logic [7:0]                        w_p_rdata;

    logic                              r_o_valid;
    clcd_pkg::t_rsp                    r_o_data;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign w_p_advance = r_p_valid && (!r_o_valid || o_rsp.ready);
    assign i_req.ready = i_rst_n && (!r_p_valid || w_p_advance);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_is_write  = i_req.data.command == clcd_pkg::CMD_WRITE;
    assign w_byte      = i_req.data.data_byte;

    // ------------------------------------------------------------------
    // Write decode: next controller state and store writes
    // ------------------------------------------------------------------
    always_comb begin
        n_caddr       = r_caddr;
        n_gaddr       = r_gaddr;
        n_gmode       = r_gmode;
        n_entry       = r_entry;
        n_dflags      = r_dflags;
        n_act         = r_act;
        n_cell_vld    = r_cell_vld;
        n_glyph_vld   = r_glyph_vld;
        w_cell_we     = 1'b0;
        w_cell_waddr  = clcd_pkg::cell_index_of(r_caddr);
        w_cell_wdata  = (w_byte == clcd_pkg::CODE_FULL_BLOCK) ? clcd_pkg::CODE_SOLID : w_byte;
        w_glyph_we    = 1'b0;
        w_glyph_wdata = w_byte[clcd_pkg::GLYPH_DW-1:0];

        if (w_accept && w_is_write) begin
            n_act = 1'b1;
            if (i_req.data.rs) begin
                // data byte
                if (r_gmode) begin
                    w_glyph_we           = 1'b1;
                    n_glyph_vld[r_gaddr] = 1'b1;
                    n_gaddr              = r_gaddr + 6'd1;
                end else begin
                    w_cell_we                 = 1'b1;
                    n_cell_vld[w_cell_waddr]  = 1'b1;
                    n_caddr = r_entry[1] ? r_caddr + 7'd1 : r_caddr - 7'd1;
                end
            end else begin
                // instruction byte
                if (w_byte == clcd_pkg::INS_NOP) begin
                    n_act = 1'b1;
                end else if (w_byte == clcd_pkg::INS_CLEAR) begin
                    n_cell_vld = '0;
                    n_caddr    = '0;
                    n_gmode    = 1'b0;
                end else if (w_byte == clcd_pkg::INS_HOME) begin
                    n_caddr = '0;
                    n_gmode = 1'b0;
                end else if ((w_byte & clcd_pkg::MASK_ENTRY) == clcd_pkg::INS_ENTRY) begin
                    n_entry = w_byte[2:0];
                end else if ((w_byte & clcd_pkg::MASK_DISPLAY) == clcd_pkg::INS_DISPLAY) begin
                    n_dflags = w_byte[2:0];
                end else if ((w_byte & clcd_pkg::MASK_SHIFT) == clcd_pkg::INS_SHIFT) begin
                    // cursor move only; display shift is ignored
                    if (!w_byte[3]) begin
                        n_caddr = w_byte[2] ? r_caddr + 7'd1 : r_caddr - 7'd1;
                    end
                end else if ((w_byte & clcd_pkg::MASK_FUNCTION) == clcd_pkg::INS_FUNCTION) begin
                    n_act = 1'b1;
                end else if ((w_byte & clcd_pkg::MASK_SET_CGRAM) == clcd_pkg::INS_SET_CGRAM) begin
                    n_gmode = 1'b1;
                    n_gaddr = w_byte[clcd_pkg::GLYPH_AW-1:0];
                end else begin
                    n_caddr = w_byte[clcd_pkg::CELL_AW-1:0];
                    n_gmode = 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Read decode: store address and read source
    // ------------------------------------------------------------------
    assign w_cell_raddr  = 7'(i_req.data.read_row) * 7'(clcd_pkg::COLS)
                         + 7'(i_req.data.read_col);
    assign w_glyph_raddr = {i_req.data.glyph_index, i_req.data.glyph_line};

    always_comb begin
        case (i_req.data.command)
            clcd_pkg::CMD_READ_CELL: begin
                w_src     = (i_req.data.read_col < 5'(clcd_pkg::COLS))
                          ? clcd_pkg::RD_CELL : clcd_pkg::RD_ZERO;
                w_src_vld = r_cell_vld[w_cell_raddr];
            end
            clcd_pkg::CMD_READ_GLYPH: begin
                w_src     = clcd_pkg::RD_GLYPH;
                w_src_vld = r_glyph_vld[w_glyph_raddr];
            end
            default: begin
                w_src     = clcd_pkg::RD_ZERO;
                w_src_vld = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Store RAMs
    // ------------------------------------------------------------------
    clcd_ram #(
        .WIDTH (8),
        .DEPTH (clcd_pkg::CELLS)
    ) u_cell_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_cell_we),
        .i_wr_addr (w_cell_waddr),
        .i_wr_data (w_cell_wdata),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_cell_raddr),
        .o_rd_data (w_cell_rdata)
    );

    clcd_ram #(
        .WIDTH (clcd_pkg::GLYPH_DW),
        .DEPTH (clcd_pkg::GLYPH_CELLS)
    ) u_glyph_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_glyph_we),
        .i_wr_addr (r_gaddr),
        .i_wr_data (w_glyph_wdata),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_glyph_raddr),
        .o_rd_data (w_glyph_rdata)
    );

    // ------------------------------------------------------------------
    // Controller state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caddr     <= '0;
            r_gaddr     <= '0;
            r_gmode     <= 1'b0;
            r_entry     <= clcd_pkg::ENTRY_RESET;
            r_dflags    <= '0;
            r_act       <= 1'b0;
            r_cell_vld  <= '0;
            r_glyph_vld <= '0;
        end else begin
            r_caddr     <= n_caddr;
            r_gaddr     <= n_gaddr;
            r_gmode     <= n_gmode;
            r_entry     <= n_entry;
            r_dflags    <= n_dflags;
            r_act       <= n_act;
            r_cell_vld  <= n_cell_vld;
            r_glyph_vld <= n_glyph_vld;
        end
    end

    // ------------------------------------------------------------------
    // Read stage: waits on RAM read data
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_accept) begin
            r_p_valid <= 1'b1;
        end else if (w_p_advance) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p_src <= w_src;
            r_p_vld <= w_src_vld;
        end
    end

    // cells never written since reset or clear read as blank, glyph rows never written since reset as zero
    always_comb begin
        case (r_p_src)
            clcd_pkg::RD_CELL:  w_p_rdata = r_p_vld ? w_cell_rdata : clcd_pkg::BLANK_CODE;
            clcd_pkg::RD_GLYPH: w_p_rdata = r_p_vld ? 8'(w_glyph_rdata) : 8'h00;
            default:            w_p_rdata = 8'h00;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register. The read stage always holds the latest request,
    // so the state registers are that request's post-access state.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_p_advance) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_advance) begin
            r_o_data.read_data       <= w_p_rdata;
            r_o_data.ddram_address   <= r_caddr;
            r_o_data.cgram_address   <= r_gaddr;
            r_o_data.cgram_selected  <= r_gmode;
            r_o_data.entry_bits      <= r_entry;
            r_o_data.display_enabled <= r_dflags[2];
            r_o_data.cursor_enabled  <= r_dflags[1];
            r_o_data.blink_enabled   <= r_dflags[0];
            r_o_data.seen_activity   <= r_act;
        end
    end

    assign o_rsp.valid = r_o_valid;
    assign o_rsp.data  = r_o_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // input backs up only when both stages are full
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (r_p_valid && r_o_valid))
        else $error("input stalled with a free stage");

    // clear drops every cell valid bit
    a_clear_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_write && !i_req.data.rs && w_byte == clcd_pkg::INS_CLEAR)
        |=> (r_cell_vld == '0))
        else $error("clear left valid cells");

    // activity flag is sticky
    a_act_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |=> r_act)
        else $error("activity flag dropped");

    // glyph data write advances the glyph counter by one
    a_glyph_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_write && i_req.data.rs && r_gmode)
        |=> (r_gaddr == $past(r_gaddr) + 6'd1) && r_gmode)
        else $error("glyph counter did not advance");
`endif

endmodule
